>>> sv/dag_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the delayed acknowledgment generator.
package dag_pkg;

   // Default width of the internal sequence arithmetic.
   localparam int DEFAULT_SEQ_WIDTH = 32;

   // Widths of the fixed fields.
   localparam int OP_W    = 2;
   localparam int REQ_SEQ_W = 32;
   localparam int ACT_W   = 3;
   localparam int RSP_SEQ_W = 32;
   localparam int COUNT_W = 4;
   localparam int DELAY_W = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 10;

   // Saturation limits of the two packet counters.
   localparam logic [COUNT_W-1:0] MAX_CONTIG  = 4'hf;
   localparam logic [COUNT_W-1:0] MAX_UNACKED = 4'hf;

   // Result queue geometry.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   // Input operation codes.
   localparam logic [OP_W-1:0] OP_PACKET = 2'd0;
   localparam logic [OP_W-1:0] OP_TIMER  = 2'd1;
   localparam logic [OP_W-1:0] OP_SEND   = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ACK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ACK  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_MS = 2'd2;

   // Configuration reset values.
   localparam logic [COUNT_W-1:0] MIN_ACK_RESET  = 4'd2;
   localparam logic [COUNT_W-1:0] MAX_ACK_RESET  = 4'd4;
   localparam logic [DELAY_W-1:0] DELAY_MS_RESET = 10'd10;

   typedef enum logic [ACT_W-1:0] {
      ACT_NONE      = 3'd0,
      ACT_DELAYED   = 3'd1,
      ACT_IMMEDIATE = 3'd2,
      ACT_SEND_ACK  = 3'd3,
      ACT_PIGGYBACK = 3'd4
   } action_type;

   typedef struct packed {
      logic [COUNT_W-1:0] min_unacked;
      logic [COUNT_W-1:0] max_unacked;
      logic [DELAY_W-1:0] delayed_ack_ms;
   } cfg_type;

   typedef struct packed {
      action_type           action;
      logic [RSP_SEQ_W-1:0] ack_seq_num;
      logic [COUNT_W-1:0]   ack_run_len;
      logic [DELAY_W-1:0]   timer_delay;
      logic                 stop_timer;
      logic                 last;
   } rsp_type;

   // One result slot handed from the step logic to the result queue.
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } slot_type;

endpackage

>>> sv/dag_req_if.sv
`timescale 1ns / 1ps
// Input channel: one event beat per handshake.
interface dag_req_if import dag_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [REQ_SEQ_W-1:0] sequence_req;
   logic                 want_ack;

   modport source (output valid, output op, output sequence_req, output want_ack,
                   input ready);
   modport sink (input valid, input op, input sequence_req, input want_ack,
                 output ready);
endinterface

>>> sv/dag_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: one action beat per handshake.
interface dag_rsp_if import dag_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ACT_W-1:0]     action;
   logic [RSP_SEQ_W-1:0] ack_seq_num;
   logic [COUNT_W-1:0]   ack_run_len;
   logic [DELAY_W-1:0]   timer_delay;
   logic                 stop_timer;
   logic                 last;

   modport source (output valid, output action, output ack_seq_num, output ack_run_len,
                   output timer_delay, output stop_timer, output last, input ready);
   modport sink (input valid, input action, input ack_seq_num, input ack_run_len,
                 input timer_delay, input stop_timer, input last, output ready);
endinterface

>>> sv/dag_step.sv
`timescale 1ns / 1ps
// Acknowledgment decision logic: next state and up to two results for one event.
module dag_step import dag_pkg::*; #(
   parameter int SEQ_WIDTH = DEFAULT_SEQ_WIDTH
) (
   input  logic [OP_W-1:0]      op,
   input  logic [SEQ_WIDTH-1:0] seq,
   input  logic                 want_ack,
   input  cfg_type              cfg,
   input  logic [SEQ_WIDTH-1:0] acked_sequence,
   input  logic [COUNT_W-1:0]   contiguous_count,
   input  logic [COUNT_W-1:0]   unacked_count,
   input  logic                 timer_armed,
   output logic [SEQ_WIDTH-1:0] acked_sequence_in,
   output logic [COUNT_W-1:0]   contiguous_count_in,
   output logic [COUNT_W-1:0]   unacked_count_in,
   output logic                 timer_armed_in,
   output slot_type             slot0,
   output slot_type             slot1
);

   logic [SEQ_WIDTH-1:0] diff;
   logic                 behind;
   logic                 in_order;
   logic [COUNT_W-1:0]   contig_inc;
   logic [COUNT_W-1:0]   unacked_inc;
   rsp_type              flush_rsp;
   rsp_type              pkt_ack_rsp;

   // Distance from the acknowledged sequence, read as signed modulo 2^SEQ_WIDTH.
   assign diff     = seq - acked_sequence;
   assign behind   = diff[SEQ_WIDTH-1];
   assign in_order = (diff == SEQ_WIDTH'(1));

   // Saturating counter increments.
   assign contig_inc  = (contiguous_count < MAX_CONTIG) ? contiguous_count + 1'b1
                                                        : contiguous_count;
   assign unacked_inc = (unacked_count < MAX_UNACKED) ? unacked_count + 1'b1
                                                      : unacked_count;

   // Flush of the pending ack as seen from the state before this event.
   always_comb begin
      flush_rsp            = '0;
      flush_rsp.stop_timer = 1'b1;
      if (unacked_count != '0) begin
         flush_rsp.action      = ACT_SEND_ACK;
         flush_rsp.ack_seq_num = RSP_SEQ_W'(acked_sequence);
         flush_rsp.ack_run_len = contiguous_count;
      end else begin
         flush_rsp.action = ACT_NONE;
      end
   end

   // Stand-alone ack of an out-of-order packet.
   always_comb begin
      pkt_ack_rsp             = '0;
      pkt_ack_rsp.action      = ACT_SEND_ACK;
      pkt_ack_rsp.ack_seq_num = RSP_SEQ_W'(seq);
   end

   // Event decision.
   always_comb begin
      acked_sequence_in   = acked_sequence;
      contiguous_count_in = contiguous_count;
      unacked_count_in    = unacked_count;
      timer_armed_in      = timer_armed;
      slot0               = '0;
      slot1               = '0;

      case (op)
         OP_PACKET: begin
            if (in_order) begin
               acked_sequence_in   = seq;
               contiguous_count_in = contig_inc;
               if (unacked_inc < cfg.max_unacked) begin
                  unacked_count_in = unacked_inc;
                  if (want_ack) begin
                     if (unacked_inc < cfg.min_unacked) begin
                        if (!timer_armed) begin
                           timer_armed_in          = 1'b1;
                           slot0.valid             = 1'b1;
                           slot0.data.action       = ACT_DELAYED;
                           slot0.data.timer_delay  = cfg.delayed_ack_ms;
                        end
                     end else begin
                        timer_armed_in    = 1'b1;
                        slot0.valid       = 1'b1;
                        slot0.data.action = ACT_IMMEDIATE;
                     end
                  end
               end else begin
                  // Enough packets outstanding: ack right away with the new state.
                  unacked_count_in        = '0;
                  timer_armed_in          = 1'b0;
                  slot0.valid             = 1'b1;
                  slot0.data.action       = ACT_SEND_ACK;
                  slot0.data.ack_seq_num  = RSP_SEQ_W'(seq);
                  slot0.data.ack_run_len  = contig_inc;
                  slot0.data.stop_timer   = 1'b1;
               end
            end else if (diff != '0) begin
               // A gap or an old packet: flush first, then maybe ack it alone.
               unacked_count_in = '0;
               timer_armed_in   = 1'b0;
               slot0.valid      = 1'b1;
               slot0.data       = flush_rsp;
               slot1.valid      = want_ack;
               slot1.data       = pkt_ack_rsp;
               if (!behind) begin
                  acked_sequence_in   = seq;
                  contiguous_count_in = '0;
               end
            end
         end
         OP_TIMER: begin
            unacked_count_in = '0;
            timer_armed_in   = 1'b0;
            slot0.valid      = 1'b1;
            slot0.data       = flush_rsp;
         end
         OP_SEND: begin
            slot0.valid            = 1'b1;
            slot0.data.action      = ACT_PIGGYBACK;
            slot0.data.ack_seq_num = RSP_SEQ_W'(acked_sequence);
            slot0.data.ack_run_len = contiguous_count;
            if (unacked_count != '0) begin
               unacked_count_in      = '0;
               timer_armed_in        = 1'b0;
               slot0.data.stop_timer = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // Mark the final result of the event.
      slot0.data.last = !slot1.valid;
      slot1.data.last = 1'b1;
   end

endmodule

>>> sv/dag_rsp_fifo.sv
`timescale 1ns / 1ps
// Result queue: takes up to two beats per cycle, gives one beat per cycle while the result channel is ready.
module dag_rsp_fifo import dag_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  slot_type  slot0,
   input  slot_type  slot1,
   output logic      room,
   dag_rsp_if.source rsp_chan
);

   rsp_type              entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff;
   logic [RSP_CNT_W-1:0] count_in;
   logic                 pop;
   logic                 push1;
   rsp_type              head;

   // Second slot is only ever used together with the first.
   assign push1 = slot0.valid && slot1.valid;
   assign pop   = rsp_chan.valid && rsp_chan.ready;

   // Room for a worst-case event of two beats.
   assign room = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(slot0.valid) + RSP_PTR_W'(push1);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in  = count_ff + RSP_CNT_W'(slot0.valid) + RSP_CNT_W'(push1)
                      - RSP_CNT_W'(pop);

   // Pointer and fill count registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (slot0.valid) begin
         entry_ff[wr_ptr_ff] <= slot0.data;
      end
      if (push1) begin
         entry_ff[wr_ptr_ff + 1'b1] <= slot1.data;
      end
   end

   // Head of the queue drives the result channel.
   assign head                  = entry_ff[rd_ptr_ff];
   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.action       = head.action;
   assign rsp_chan.ack_seq_num  = head.ack_seq_num;
   assign rsp_chan.ack_run_len  = head.ack_run_len;
   assign rsp_chan.timer_delay  = head.timer_delay;
   assign rsp_chan.stop_timer   = head.stop_timer;
   assign rsp_chan.last         = head.last;

endmodule

>>> sv/delayed_ack_generator_unit.sv
`timescale 1ns / 1ps
// Results of an accepted event are registered in the result queue and offered from its head.
// One event per cycle while the result queue has room; two result beats go out in turn.
// req_chan.ready drops while the result queue holds more than two beats.
// Reset (synchronous, active high) clears the ack state and the queue and loads the
// register defaults: min_unacked 2, max_unacked 4, delayed_ack_ms 10.
module delayed_ack_generator_unit import dag_pkg::*; #(
   parameter int SEQ_WIDTH = DEFAULT_SEQ_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   dag_req_if.sink               req_chan,
   dag_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [SEQ_WIDTH-1:0] acked_sequence_ff;
   logic [SEQ_WIDTH-1:0] acked_sequence_in;
   logic [COUNT_W-1:0]   contiguous_count_ff;
   logic [COUNT_W-1:0]   contiguous_count_in;
   logic [COUNT_W-1:0]   unacked_count_ff;
   logic [COUNT_W-1:0]   unacked_count_in;
   logic                 timer_armed_ff;
   logic                 timer_armed_in;
   logic                 accept;
   logic                 room;
   slot_type             step0;
   slot_type             step1;
   slot_type             slot0;
   slot_type             slot1;

   assign req_chan.ready = room;
   assign accept         = req_chan.valid && req_chan.ready;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_ACK:  cfg_in.min_unacked    = COUNT_W'(csr_wdata);
            CSR_MAX_ACK:  cfg_in.max_unacked    = COUNT_W'(csr_wdata);
            CSR_DELAY_MS: cfg_in.delayed_ack_ms = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_unacked    <= MIN_ACK_RESET;
         cfg_ff.max_unacked    <= MAX_ACK_RESET;
         cfg_ff.delayed_ack_ms <= DELAY_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Decision logic for the event on the input channel.
   dag_step #(
      .SEQ_WIDTH (SEQ_WIDTH)
   ) u_step (
      .op                  (req_chan.op),
      .seq                 (SEQ_WIDTH'(req_chan.sequence_req)),
      .want_ack            (req_chan.want_ack),
      .cfg                 (cfg_ff),
      .acked_sequence      (acked_sequence_ff),
      .contiguous_count    (contiguous_count_ff),
      .unacked_count       (unacked_count_ff),
      .timer_armed         (timer_armed_ff),
      .acked_sequence_in   (acked_sequence_in),
      .contiguous_count_in (contiguous_count_in),
      .unacked_count_in    (unacked_count_in),
      .timer_armed_in      (timer_armed_in),
      .slot0               (step0),
      .slot1               (step1)
   );

   // Ack state advances only on an accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         acked_sequence_ff   <= '0;
         contiguous_count_ff <= '0;
         unacked_count_ff    <= '0;
         timer_armed_ff      <= 1'b0;
      end else if (accept) begin
         acked_sequence_ff   <= acked_sequence_in;
         contiguous_count_ff <= contiguous_count_in;
         unacked_count_ff    <= unacked_count_in;
         timer_armed_ff      <= timer_armed_in;
      end
   end

   // Results enter the queue only for an accepted beat.
   always_comb begin
      slot0       = step0;
      slot1       = step1;
      slot0.valid = step0.valid && accept;
      slot1.valid = step1.valid && accept;
   end

   dag_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .slot0    (slot0),
      .slot1    (slot1),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

   // An armed ack timer always has something pending to acknowledge.
   assert property (@(posedge clock) disable iff (reset)
      timer_armed_ff |-> (unacked_count_ff != '0))
      else $error("ack timer armed with no unacknowledged packets");

   // A timer expiry leaves nothing pending and the timer idle.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.op == OP_TIMER)) |=> (!timer_armed_ff && (unacked_count_ff == '0)))
      else $error("timer expiry did not clear the pending ack");

   // An accepted data send always queues its piggyback beat.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.op == OP_SEND)) |=> rsp_chan.valid)
      else $error("data send gave no piggyback beat");

endmodule
